// File: rtl/core/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // per-update control broadcast to every cell
    typedef struct packed {
        logic commit;
        logic shift;
        logic insert;
    } lkvc_ctrl_t;

endpackage

// File: rtl/core/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// one recency slot: holds key, data and valid, compares against the lookup
// key and takes its neighbor's entry when the row shifts
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_BITS  = 4,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lkvc_pkg::lkvc_ctrl_t  ctrl,
    input  logic [IDX_BITS-1:0]   upd_limit,
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [DATA_BITS-1:0]  prev_data,
    output logic [KEY_BITS-1:0]   key_out,
    output logic [DATA_BITS-1:0]  data_out,
    output logic                  match
);
    import lkvc_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic                 in_range;
    logic                 load;

    assign in_range = (IDX_BITS'(INDEX) <= upd_limit);
    assign load     = ctrl.commit && ctrl.shift && in_range;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.commit && ctrl.insert) begin
            valid_next = in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            key_reg  <= prev_key;
            data_reg <= prev_data;
        end
    end

    assign match    = valid_reg && (key_reg == cmp_key);
    assign key_out  = key_reg;
    assign data_out = data_reg;

endmodule

// File: rtl/core/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// an item is compared, then updated; the update commits only when the output is free
// and registers the result; a new item is taken while idle or as the last one commits
// reset: all entries invalid, fill count zero, capacity 16; no clearing pass
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wr_data,   // capacity_limit
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lkvc_pkg::S_DATA_W-1:0]  s_tdata,       // lookup_key, store_value
    input  logic                           s_tuser,       // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lkvc_pkg::M_DATA_W-1:0]  m_tdata        // hit, read_value, evicted, pad
);
    import lkvc_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam int KW = (KEY_BITS > FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int DW = (DATA_BITS > FIELD_W) ? DATA_BITS : FIELD_W;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t               state_reg, state_next;
    logic                 req_op_reg;
    logic [KEY_BITS-1:0]  req_key_reg;
    logic [DATA_BITS-1:0] req_val_reg;
    logic                 hit_reg;
    logic [IW-1:0]        pos_reg;
    logic [DATA_BITS-1:0] hit_data_reg;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CAP_W-1:0]     cap_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_hit_reg;
    logic [FIELD_W-1:0]   m_read_reg, m_read_next;
    logic                 m_evict_reg, m_evict_next;

    logic [KW-1:0]        key_wide;
    logic [DW-1:0]        val_wide;
    logic [DW-1:0]        rd_wide;
    logic                 s_accept;
    logic                 out_free;
    logic                 commit;
    lkvc_ctrl_t           ctrl;
    logic [EW-1:0]        cap_e, eff_cap, fill_e, fill_trunc;
    logic                 full;
    logic [IW-1:0]        upd_limit;
    logic [KEY_BITS-1:0]  head_key;
    logic [DATA_BITS-1:0] head_data;

    logic [DEPTH-1:0]     match_vec;
    logic [KEY_BITS-1:0]  cell_key  [DEPTH];
    logic [DATA_BITS-1:0] cell_data [DEPTH];
    logic [IW-1:0]        pos_enc;
    logic [DATA_BITS-1:0] data_sel;

    assign key_wide = KW'(s_tdata[FIELD_W-1:0]);
    assign val_wide = DW'(s_tdata[2*FIELD_W-1:FIELD_W]);
    assign rd_wide  = DW'(hit_data_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_UPD) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign s_accept = s_tvalid && s_tready;

    // capacity clamp and eviction check
    always_comb begin
        cap_e   = EW'(cap_reg);
        eff_cap = cap_e;
        if (cap_e == '0) begin
            eff_cap = EW'(1);
        end else if (cap_e > DEPTH_E) begin
            eff_cap = DEPTH_E;
        end
        fill_e     = EW'(fill_reg);
        full       = (fill_e >= eff_cap);
        fill_trunc = full ? (eff_cap - EW'(1)) : fill_e;
    end

    assign ctrl.commit = commit;
    assign ctrl.shift  = (req_op_reg == OP_SET) || hit_reg;
    assign ctrl.insert = (req_op_reg == OP_SET) && !hit_reg;
    assign upd_limit   = hit_reg ? pos_reg : fill_trunc[IW-1:0];
    assign head_key    = req_key_reg;
    assign head_data   = (req_op_reg == OP_GET) ? hit_data_reg : req_val_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [KEY_BITS-1:0]  prev_key;
            logic [DATA_BITS-1:0] prev_data;
            if (gi == 0) begin : g_head
                assign prev_key  = head_key;
                assign prev_data = head_data;
            end else begin : g_link
                assign prev_key  = cell_key[gi-1];
                assign prev_data = cell_data[gi-1];
            end
            lkvc_cell #(
                .INDEX     (gi),
                .IDX_BITS  (IW),
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .upd_limit (upd_limit),
                .cmp_key   (req_key_reg),
                .prev_key  (prev_key),
                .prev_data (prev_data),
                .key_out   (cell_key[gi]),
                .data_out  (cell_data[gi]),
                .match     (match_vec[gi])
            );
        end
    endgenerate

    // keys are unique among valid cells, so at most one match
    always_comb begin
        pos_enc  = '0;
        data_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match_vec[i]) begin
                pos_enc  = pos_enc | IW'(i);
                data_sel = data_sel | cell_data[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = s_tvalid ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg;
        m_read_next   = '0;
        m_evict_next  = 1'b0;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (commit) begin
            m_tvalid_next = 1'b1;
            if (ctrl.insert) begin
                fill_next    = CW'(fill_trunc + EW'(1));
                m_evict_next = full;
            end
            if (req_op_reg == OP_GET && hit_reg) begin
                m_read_next = rd_wide[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
        if (s_accept) begin
            req_op_reg  <= s_tuser;
            req_key_reg <= key_wide[KEY_BITS-1:0];
            req_val_reg <= val_wide[DATA_BITS-1:0];
        end
        if (state_reg == ST_CMP) begin
            hit_reg      <= |match_vec;
            pos_reg      <= pos_enc;
            hit_data_reg <= data_sel;
        end
        if (commit) begin
            m_hit_reg   <= hit_reg;
            m_read_reg  <= m_read_next;
            m_evict_reg <= m_evict_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - FIELD_W - 2)'(0), m_evict_reg, m_read_reg, m_hit_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> $onehot0(match_vec))
        else $error("duplicate key in cell row");

    a_accept_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_CMP))
        else $error("accepted item not compared");

    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_evict_reg) |-> !m_hit_reg)
        else $error("eviction on a hit");

    a_read_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_read_reg != '0)) |-> m_hit_reg)
        else $error("read value without hit");
`endif

endmodule

// File: bench/lru_key_value_cache_checker.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// passive checker for the lru key-value cache: keeps its own recency-ordered
// copy of the entries and the capacity register, predicts the response of
// every accepted request and compares it field by field with the responses
// leaving the block, oldest first
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lkvc_pkg::S_DATA_W-1:0]  s_tdata,      // lookup_key, store_value
    input  logic                           s_tuser,      // opcode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lkvc_pkg::M_DATA_W-1:0]  m_tdata,      // hit, read_value, evicted, pad
    input  logic                           end_of_test,
    output int                             mismatch_count
);
    import lkvc_pkg::*;

    typedef struct packed {
        logic               evicted;
        logic [FIELD_W-1:0] read_value;
        logic               hit;
    } access_result_t;

    logic [FIELD_W-1:0] entry_key  [DEPTH];
    logic [FIELD_W-1:0] entry_data [DEPTH];
    int                 fill_level;
    logic [CAP_W-1:0]   capacity;
    access_result_t     pending_results[$];
    access_result_t     want;

    initial mismatch_count = 0;

    // position 0 holds the most recent entry
    function automatic access_result_t cache_access(input logic               op,
                                                    input logic [FIELD_W-1:0] key,
                                                    input logic [FIELD_W-1:0] val);
        access_result_t     res;
        int                 pos;
        int                 cap;
        int                 i;
        logic [FIELD_W-1:0] moved_key;
        logic [FIELD_W-1:0] moved_data;
        res = '0;
        pos = -1;
        for (i = fill_level - 1; i >= 0; i--)
            if (entry_key[i] == key) pos = i;
        res.hit = (pos >= 0);
        if (pos >= 0) begin
            if (op == OP_GET) res.read_value = entry_data[pos];
            else entry_data[pos] = val;
            moved_key  = entry_key[pos];
            moved_data = entry_data[pos];
            for (i = pos; i > 0; i--) begin
                entry_key[i]  = entry_key[i-1];
                entry_data[i] = entry_data[i-1];
            end
            entry_key[0]  = moved_key;
            entry_data[0] = moved_data;
        end else if (op == OP_SET) begin
            // zero acts as one, anything above the depth as the depth
            cap = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : int'(capacity);
            // a lowered capacity trims the oldest entries at the next insert
            if (fill_level >= cap) begin
                fill_level  = cap - 1;
                res.evicted = 1'b1;
            end
            for (i = fill_level; i > 0; i--) begin
                entry_key[i]  = entry_key[i-1];
                entry_data[i] = entry_data[i-1];
            end
            entry_key[0]  = key;
            entry_data[0] = val;
            fill_level++;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_level = 0;
            capacity   = CAP_RESET;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("response %h with no request outstanding",
                                              m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch($sformatf("hit %b, predicted %b",
                                                  m_tdata[0], want.hit));
                    if (m_tdata[FIELD_W:1] !== want.read_value)
                        report_mismatch($sformatf("read_value %h, predicted %h",
                                                  m_tdata[FIELD_W:1], want.read_value));
                    if (m_tdata[FIELD_W+1] !== want.evicted)
                        report_mismatch($sformatf("evicted %b, predicted %b",
                                                  m_tdata[FIELD_W+1], want.evicted));
                end
            end
            if (cfg_wr_en) capacity = cfg_wr_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(cache_access(s_tuser, s_tdata[FIELD_W-1:0],
                                                       s_tdata[2*FIELD_W-1:FIELD_W]));
            if (end_of_test) begin
                while (pending_results.size() != 0) begin
                    want = pending_results.pop_front();
                    report_mismatch($sformatf("predicted response %h never came", want));
                end
            end
        end
    end

endmodule

// File: bench/lru_key_value_cache_top_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb
// drives get and set requests into the lru key-value cache: a directed run
// over the key and value extremes, updates, misses and a capacity lowered
// below the fill level, then random phases under several capacity settings
// with small key pools for frequent hits and evictions, random idling on
// both streams and one long response stall; the checker gives the verdict
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
    import lkvc_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AT        = 500;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 170;
    localparam int POOL_SIZE      = 20;
    localparam int DRAIN_CYCLES   = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CAP_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;      // lookup_key, store_value
    logic                  s_tuser;      // opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;      // hit, read_value, evicted, pad
    logic                  end_of_test;
    int                    mismatch_count;

    int                    idle_pct = 25;
    int                    sent_count;
    int                    done_count;
    int                    quiet_cycles;
    bit                    long_hold_done = 1'b0;
    logic [FIELD_W-1:0]    key_pool [POOL_SIZE];
    logic [CAP_W-1:0]      phase_capacity [RANDOM_PHASES] =
        '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd5};

    lru_key_value_cache_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    lru_key_value_cache_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .end_of_test    (end_of_test),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            sent_count   <= 0;
            done_count   <= 0;
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready) sent_count <= sent_count + 1;
            if (m_tvalid && m_tready) done_count <= done_count + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // response side: random stalls, plus one long hold-off to back up the cache
    initial begin
        forever begin
            if (!long_hold_done && sent_count >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // leaves s_tvalid high after the accepting edge, so back-to-back items stay valid
    task automatic send_item(input logic op, input logic [FIELD_W-1:0] key,
                             input logic [FIELD_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (done_count != sent_count);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                 phase;
        int                 n;
        int                 eff;
        int                 pool_n;
        logic               op;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] val;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_GET;
        s_tdata     <= '0;
        end_of_test <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // capacity still at its reset value
        send_item(OP_GET, 32'h0000_0000, 32'hdead_beef);
        send_item(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(OP_SET, 32'h7fff_ffff, 32'h5a5a_5a5a);
        send_item(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(OP_GET, 32'ha5a5_a5a5, 32'h0000_0000);
        send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);

        // capacity below the fill level: old entries linger until the next insert
        write_capacity(5'd2);
        send_item(OP_GET, 32'hffff_ffff, 32'h0000_0000);
        send_item(OP_SET, 32'h0000_ffff, 32'h1234_5678);
        send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(OP_SET, 32'hffff_0000, 32'h8765_4321);
        send_item(OP_GET, 32'h0000_ffff, 32'h0000_0000);

        // zero acts as one
        write_capacity(5'd0);
        send_item(OP_SET, 32'h1357_9bdf, 32'h2468_ace0);
        send_item(OP_SET, 32'h1357_9bdf, 32'h0000_0000);
        send_item(OP_GET, 32'h1357_9bdf, 32'h0000_0000);
        send_item(OP_SET, 32'h0246_8ace, 32'hffff_ffff);
        send_item(OP_GET, 32'h1357_9bdf, 32'h0000_0000);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_capacity(phase_capacity[phase]);
            idle_pct = (phase == 3 || phase == RANDOM_PHASES - 1) ? 0 : 25;
            eff = (phase_capacity[phase] == 0) ? 1 :
                  (phase_capacity[phase] > DEPTH) ? DEPTH : int'(phase_capacity[phase]);
            pool_n = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hffff_ffff;
            key_pool[2] = 32'h8000_0000;
            key_pool[3] = 32'h7fff_ffff;
            for (n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                op  = ($urandom_range(1, 0) == 1) ? OP_SET : OP_GET;
                key = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(pool_n - 1, 0)]
                                                   : $urandom();
                case ($urandom_range(9, 0))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    default: val = $urandom();
                endcase
                send_item(op, key, val);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
